// ===== rtl/core/p1305_pkg.sv =====
// Shared constants, types and helper functions for the Poly1305 tag engine.
package p1305_pkg;

	// Field and register widths
	localparam int WORD_W = 64;
	localparam int CNT_W = 5;
	localparam int BLK_BYTES = 16;
	localparam int NUM_REGS = 4;
	localparam int REG_IDX_W = 2;
	localparam int ADDR_W = 5;

	// Radix 2^26 limb arithmetic
	localparam int LIMB_W = 26;
	localparam int LIMB_COUNT = 5;
	localparam int LIMB_IDX_W = 3;
	localparam int ACC_W = LIMB_W * LIMB_COUNT;
	localparam int PAD_W = 8 * BLK_BYTES + 1;
	localparam int HSUM_W = LIMB_W + 1;
	localparam int RMUL_W = LIMB_W + 3;
	localparam int PROD_W = HSUM_W + RMUL_W;
	localparam int ROW_W = PROD_W + 3;
	localparam int SUM_W = ROW_W + 1;
	localparam int COUT_W = SUM_W - LIMB_W;
	localparam int CARRY_W = COUT_W + 3;

	// Clamp masks applied to the key halves that form r
	localparam logic [WORD_W-1:0] CLAMP_LOW = 64'h0FFF_FFFC_0FFF_FFFF;
	localparam logic [WORD_W-1:0] CLAMP_HIGH = 64'h0FFF_FFFC_0FFF_FFFC;

	// Register indexes on the configuration port
	localparam logic [REG_IDX_W-1:0] REG_R_LOW = 2'd0;
	localparam logic [REG_IDX_W-1:0] REG_R_HIGH = 2'd1;
	localparam logic [REG_IDX_W-1:0] REG_S_LOW = 2'd2;
	localparam logic [REG_IDX_W-1:0] REG_S_HIGH = 2'd3;

	typedef logic [WORD_W-1:0] word_t;
	typedef logic [CNT_W-1:0] count_t;
	typedef logic [LIMB_W-1:0] limb_t;
	typedef logic [PAD_W-1:0] pad_t;

	// Keep the valid bytes of a block and place the 0x01 pad byte above them.
	// A count above sixteen is treated as a full block.
	function automatic pad_t pad_block(input word_t lo, input word_t hi, input count_t cnt);
		logic [8*BLK_BYTES-1:0] data;
		pad_t res;
		count_t n;
		data = {hi, lo};
		n = (cnt > count_t'(BLK_BYTES)) ? count_t'(BLK_BYTES) : cnt;
		res = '0;
		for (int b = 0; b < BLK_BYTES; b++) begin
			if (count_t'(b) < n) begin
				res[8*b +: 8] = data[8*b +: 8];
			end
		end
		res[{n, 3'b000}] = 1'b1;
		return res;
	endfunction

endpackage

// ===== rtl/core/p1305_if.sv =====
// Valid/ready channel interfaces for message blocks and tags.
interface p1305_msg_if;
	import p1305_pkg::*;

	logic valid;
	logic ready;
	word_t data_low;
	word_t data_high;
	count_t byte_count;
	logic last_block;

	modport source(output valid, output data_low, output data_high, output byte_count,
		output last_block, input ready);
	modport sink(input valid, input data_low, input data_high, input byte_count,
		input last_block, output ready);
endinterface

interface p1305_tag_if;
	import p1305_pkg::*;

	logic valid;
	logic ready;
	word_t tag_low;
	word_t tag_high;

	modport source(output valid, output tag_low, output tag_high, input ready);
	modport sink(input valid, input tag_low, input tag_high, output ready);
endinterface

// ===== rtl/core/poly1305_tag_engine_core.sv =====
// Poly1305 tag engine: key registers, block absorb, shared multiplier and tag output.
// Steps: a block word is loaded, then its 25 limb products run on the shared 27x29
// multiplier, the multiplier stage drains and 15 carry steps follow; a last word then
// adds the final reduction and the tag add. An empty last word goes straight to them.
// A new word is taken only in idle, once the single multiplier and carry adder are free.
// Reset: arst_n clears the key registers, the accumulator and all control state.
module poly1305_tag_engine_core (
	input  logic clk,
	input  logic arst_n,
	p1305_msg_if.sink msg,
	p1305_tag_if.source tag,
	input  logic psel,
	input  logic penable,
	input  logic pwrite,
	input  logic [p1305_pkg::ADDR_W-1:0] paddr,
	input  p1305_pkg::word_t pwdata,
	output p1305_pkg::word_t prdata,
	output logic pready
);
	import p1305_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_MUL = 3'd1;
	localparam logic [2:0] S_DRAIN = 3'd2;
	localparam logic [2:0] S_CARRY = 3'd3;
	localparam logic [2:0] S_FIN1 = 3'd4;
	localparam logic [2:0] S_FIN2 = 3'd5;

	localparam logic [LIMB_IDX_W-1:0] LAST_LIMB = LIMB_IDX_W'(LIMB_COUNT - 1);
	localparam logic [1:0] LAST_PASS = 2'd2;

	logic [2:0] state_q;
	word_t key_q [NUM_REGS];
	logic [HSUM_W-1:0] h_q [LIMB_COUNT];
	logic [ROW_W-1:0] d_q [LIMB_COUNT];
	logic [LIMB_IDX_W-1:0] i_q, j_q, limb_q;
	logic [1:0] pass_q;
	logic [CARRY_W-1:0] carry_q;
	logic last_q;
	logic [PROD_W-1:0] prod_s1;
	logic [LIMB_IDX_W-1:0] row_s1;
	logic vld_s1;
	logic [8*BLK_BYTES-1:0] hv_q;
	word_t tag_low_q, tag_high_q;
	logic out_valid_q;

	logic msg_acc;
	logic cfg_wr;
	pad_t pad;
	limb_t m_limb [LIMB_COUNT];
	logic [8*BLK_BYTES-1:0] r_clamped;
	limb_t r_limb [LIMB_COUNT];
	logic [RMUL_W-1:0] r5_limb [LIMB_COUNT];
	logic [LIMB_IDX_W-1:0] r_idx;
	logic [RMUL_W-1:0] r_sel;
	logic [SUM_W-1:0] t_sum;
	logic [COUT_W-1:0] c_out;
	logic [CARRY_W-1:0] c_next;
	logic [ACC_W-1:0] h_val;
	logic [ACC_W:0] g_val;
	logic [8*BLK_BYTES-1:0] tag_sum;
	logic tag_load;

	// Configuration port: writes land in the key registers, reads return them.
	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite && pready;
	assign prdata = key_q[paddr[ADDR_W-1 -: REG_IDX_W]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NUM_REGS; k++) key_q[k] <= '0;
		end else if (cfg_wr) begin
			key_q[paddr[ADDR_W-1 -: REG_IDX_W]] <= pwdata;
		end
	end

	// Padded message block split into radix 2^26 limbs.
	assign pad = pad_block(msg.data_low, msg.data_high, msg.byte_count);
	always_comb begin
		for (int k = 0; k < LIMB_COUNT - 1; k++) m_limb[k] = pad[LIMB_W*k +: LIMB_W];
		m_limb[LIMB_COUNT-1] = limb_t'(pad[PAD_W-1:LIMB_W*(LIMB_COUNT-1)]);
	end

	// Clamped r and its times-five copies for the wrapped partial products.
	assign r_clamped = {key_q[REG_R_HIGH] & CLAMP_HIGH, key_q[REG_R_LOW] & CLAMP_LOW};
	always_comb begin
		for (int k = 0; k < LIMB_COUNT - 1; k++) r_limb[k] = r_clamped[LIMB_W*k +: LIMB_W];
		r_limb[LIMB_COUNT-1] = limb_t'(r_clamped[8*BLK_BYTES-1:LIMB_W*(LIMB_COUNT-1)]);
		for (int k = 0; k < LIMB_COUNT; k++) begin
			r5_limb[k] = RMUL_W'(r_limb[k]) + (RMUL_W'(r_limb[k]) << 2);
		end
	end

	// Operand select for the product of accumulator limb j and r limb i-j.
	always_comb begin
		if (i_q >= j_q) begin
			r_idx = i_q - j_q;
			r_sel = RMUL_W'(r_limb[r_idx]);
		end else begin
			r_idx = i_q + LIMB_IDX_W'(LIMB_COUNT) - j_q;
			r_sel = r5_limb[r_idx];
		end
	end

	// Carry step on one limb; the carry out of the top limb wraps back times five.
	assign t_sum = SUM_W'(d_q[limb_q]) + SUM_W'(carry_q);
	assign c_out = t_sum[SUM_W-1:LIMB_W];
	assign c_next = (limb_q == LAST_LIMB) ? (CARRY_W'(c_out) + (CARRY_W'(c_out) << 2))
		: CARRY_W'(c_out);

	// Final reduction: subtract p once when h + 5 reaches 2^130, then add s.
	assign h_val = {h_q[4][LIMB_W-1:0], h_q[3][LIMB_W-1:0], h_q[2][LIMB_W-1:0],
		h_q[1][LIMB_W-1:0], h_q[0][LIMB_W-1:0]};
	assign g_val = {1'b0, h_val} + (ACC_W+1)'(5);
	assign tag_sum = hv_q + {key_q[REG_S_HIGH], key_q[REG_S_LOW]};

	assign msg.ready = (state_q == S_IDLE);
	assign msg_acc = msg.valid && msg.ready;
	assign tag_load = (state_q == S_FIN2) && (!out_valid_q || tag.ready);

	// Sequencer and accumulator.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			i_q <= '0;
			j_q <= '0;
			limb_q <= '0;
			pass_q <= '0;
			carry_q <= '0;
			last_q <= 1'b0;
			vld_s1 <= 1'b0;
			for (int k = 0; k < LIMB_COUNT; k++) h_q[k] <= '0;
		end else begin
			vld_s1 <= (state_q == S_MUL);
			case (state_q)
				S_IDLE: begin
					if (msg_acc) begin
						last_q <= msg.last_block;
						i_q <= '0;
						j_q <= '0;
						if (msg.byte_count != '0) begin
							for (int k = 0; k < LIMB_COUNT; k++) begin
								h_q[k] <= h_q[k] + HSUM_W'(m_limb[k]);
							end
							state_q <= S_MUL;
						end else if (msg.last_block) begin
							state_q <= S_FIN1;
						end
					end
				end
				S_MUL: begin
					if (j_q == LAST_LIMB) begin
						j_q <= '0;
						if (i_q == LAST_LIMB) begin
							state_q <= S_DRAIN;
						end else begin
							i_q <= i_q + 1'b1;
						end
					end else begin
						j_q <= j_q + 1'b1;
					end
				end
				S_DRAIN: begin
					limb_q <= '0;
					pass_q <= '0;
					carry_q <= '0;
					state_q <= S_CARRY;
				end
				S_CARRY: begin
					h_q[limb_q] <= HSUM_W'(t_sum[LIMB_W-1:0]);
					carry_q <= c_next;
					if (limb_q == LAST_LIMB) begin
						limb_q <= '0;
						if (pass_q == LAST_PASS) begin
							state_q <= last_q ? S_FIN1 : S_IDLE;
						end else begin
							pass_q <= pass_q + 1'b1;
						end
					end else begin
						limb_q <= limb_q + 1'b1;
					end
				end
				S_FIN1: begin
					state_q <= S_FIN2;
				end
				S_FIN2: begin
					if (tag_load) begin
						for (int k = 0; k < LIMB_COUNT; k++) h_q[k] <= '0;
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// Multiplier stage and row accumulation; the carry walk reuses the row registers.
	always_ff @(posedge clk) begin
		prod_s1 <= PROD_W'(h_q[j_q]) * PROD_W'(r_sel);
		row_s1 <= i_q;
		if (msg_acc) begin
			for (int k = 0; k < LIMB_COUNT; k++) d_q[k] <= '0;
		end else if (vld_s1) begin
			d_q[row_s1] <= d_q[row_s1] + ROW_W'(prod_s1);
		end else if (state_q == S_CARRY) begin
			d_q[limb_q] <= ROW_W'(t_sum[LIMB_W-1:0]);
		end
		if (state_q == S_FIN1) begin
			hv_q <= g_val[ACC_W] ? g_val[8*BLK_BYTES-1:0] : h_val[8*BLK_BYTES-1:0];
		end
		if (tag_load) begin
			tag_low_q <= tag_sum[WORD_W-1:0];
			tag_high_q <= tag_sum[2*WORD_W-1:WORD_W];
		end
	end

	// Output register: holds the tag word until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (tag_load) begin
			out_valid_q <= 1'b1;
		end else if (tag.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign tag.valid = out_valid_q;
	assign tag.tag_low = tag_low_q;
	assign tag.tag_high = tag_high_q;

	// The last carry pass never carries out of the top limb.
	a_carry_settled: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_CARRY && pass_q == LAST_PASS && limb_q == LAST_LIMB) |-> (c_out == '0))
		else $error("carry left over after final pass");

	// Between words the accumulator limbs are fully carried.
	a_limbs_carried: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_IDLE) |-> (h_q[0][LIMB_W] == 1'b0 && h_q[1][LIMB_W] == 1'b0 &&
		h_q[2][LIMB_W] == 1'b0 && h_q[3][LIMB_W] == 1'b0 && h_q[4][LIMB_W] == 1'b0))
		else $error("accumulator limb not carried");

	// An empty last word goes straight to the final reduction.
	a_empty_last: assert property (@(posedge clk) disable iff (!arst_n)
		(msg_acc && msg.last_block && msg.byte_count == '0) |=> (state_q == S_FIN1))
		else $error("empty last word did not start reduction");

	// A new tag only appears from the tag add step.
	a_tag_source: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> ($past(state_q) == S_FIN2))
		else $error("tag valid raised outside tag add");

	// Product limb counters stay within the five limbs.
	a_mul_index: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_MUL) |-> (i_q <= LAST_LIMB && j_q <= LAST_LIMB))
		else $error("limb counter out of range");

endmodule
